>>> rtl/ifq_pkg.sv
// shared types, constants and helpers for the image fit transform
`timescale 1ns / 1ps
`default_nettype none
package ifq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SIZE_W    = 16;
   localparam int NUM_W     = 48;
   localparam int DIV_STEPS = NUM_W;
   localparam int LANES     = 4;
   localparam int SCALE_W   = 32;
   localparam int OFS_W     = 48;

   localparam logic [SCALE_W-1:0] ONE_Q = SCALE_W'(1) << FRAC_BITS;

   // divider lanes
   localparam int LANE_DW = 0;  // iw*h*one / ih
   localparam int LANE_DH = 1;  // ih*w*one / iw
   localparam int LANE_SW = 2;  // iw*one / w
   localparam int LANE_SH = 3;  // ih*one / h

   // configuration register indexes
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   typedef enum logic [2:0] {
      MODE_STRETCH = 3'd0,
      MODE_FILL    = 3'd1,
      MODE_FIT     = 3'd2,
      MODE_CENTER  = 3'd3,
      MODE_TILE    = 3'd4,
      MODE_OTHER   = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic [SIZE_W-1:0] iw;
      logic [SIZE_W-1:0] ih;
   } side_type;

   typedef struct packed {
      logic              covers;
      logic [SCALE_W-1:0] sy;
      logic [SCALE_W-1:0] sx;
      logic [OFS_W-1:0]  oy;
      logic [OFS_W-1:0]  ox;
   } result_type;

   // a zero size counts as one pixel
   function automatic logic [SIZE_W-1:0] size_or_one(input logic [SIZE_W-1:0] v);
      return (v == '0) ? SIZE_W'(1) : v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ifq_div_pipe.sv
// four-lane restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps
`default_nettype none
module ifq_div_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire ifq_pkg::side_type             in_side,
   input  wire logic [ifq_pkg::NUM_W-1:0]     in_num [ifq_pkg::LANES],
   input  wire logic [ifq_pkg::SIZE_W-1:0]    in_den [ifq_pkg::LANES],
   output logic                               out_valid,
   output ifq_pkg::side_type                  out_side,
   output logic [ifq_pkg::NUM_W-1:0]          out_quo [ifq_pkg::LANES]
);

   logic                         valid_ff [ifq_pkg::DIV_STEPS];
   ifq_pkg::side_type            side_ff  [ifq_pkg::DIV_STEPS];
   logic [ifq_pkg::SIZE_W-1:0]   rem_ff   [ifq_pkg::DIV_STEPS][ifq_pkg::LANES];
   logic [ifq_pkg::NUM_W-1:0]    acc_ff   [ifq_pkg::DIV_STEPS][ifq_pkg::LANES];
   logic [ifq_pkg::SIZE_W-1:0]   den_ff   [ifq_pkg::DIV_STEPS][ifq_pkg::LANES];

   logic [ifq_pkg::SIZE_W-1:0]   rem_in   [ifq_pkg::DIV_STEPS][ifq_pkg::LANES];
   logic [ifq_pkg::NUM_W-1:0]    acc_in   [ifq_pkg::DIV_STEPS][ifq_pkg::LANES];

   for (genvar k = 0; k < ifq_pkg::DIV_STEPS; k++) begin : g_step
      logic                       vld_src;
      ifq_pkg::side_type          side_src;
      logic [ifq_pkg::SIZE_W-1:0] rem_src [ifq_pkg::LANES];
      logic [ifq_pkg::NUM_W-1:0]  acc_src [ifq_pkg::LANES];
      logic [ifq_pkg::SIZE_W-1:0] den_src [ifq_pkg::LANES];

      // stage source: the ports for the first step, the previous stage otherwise
      if (k == 0) begin : g_first
         always_comb begin
            vld_src  = in_valid;
            side_src = in_side;
            for (int l = 0; l < ifq_pkg::LANES; l++) begin
               rem_src[l] = '0;
               acc_src[l] = in_num[l];
               den_src[l] = in_den[l];
            end
         end
      end else begin : g_next
         always_comb begin
            vld_src  = valid_ff[k-1];
            side_src = side_ff[k-1];
            for (int l = 0; l < ifq_pkg::LANES; l++) begin
               rem_src[l] = rem_ff[k-1][l];
               acc_src[l] = acc_ff[k-1][l];
               den_src[l] = den_ff[k-1][l];
            end
         end
      end

      // one compare and subtract per lane
      always_comb begin
         logic [ifq_pkg::SIZE_W:0] trial;
         trial = '0;
         for (int l = 0; l < ifq_pkg::LANES; l++) begin
            trial = {rem_src[l], acc_src[l][ifq_pkg::NUM_W-1]};
            if (trial >= {1'b0, den_src[l]}) begin
               rem_in[k][l] = ifq_pkg::SIZE_W'(trial - {1'b0, den_src[l]});
               acc_in[k][l] = {acc_src[l][ifq_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = trial[ifq_pkg::SIZE_W-1:0];
               acc_in[k][l] = {acc_src[l][ifq_pkg::NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_src;
            for (int l = 0; l < ifq_pkg::LANES; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               acc_ff[k][l] <= acc_in[k][l];
               den_ff[k][l] <= den_src[l];
            end
         end
      end
   end

   assign out_valid = valid_ff[ifq_pkg::DIV_STEPS-1];
   assign out_side  = side_ff[ifq_pkg::DIV_STEPS-1];
   always_comb begin
      for (int l = 0; l < ifq_pkg::LANES; l++) begin
         out_quo[l] = acc_ff[ifq_pkg::DIV_STEPS-1][l];
      end
   end

endmodule
`default_nettype wire

>>> rtl/ifq_post.sv
// scale selection, centering offsets and coverage flag, four stages
`timescale 1ns / 1ps
`default_nettype none
module ifq_post (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire ifq_pkg::side_type         in_side,
   input  wire logic [ifq_pkg::NUM_W-1:0] in_quo [ifq_pkg::LANES],
   output logic                           out_valid,
   output ifq_pkg::result_type            out_result
);

   localparam int DW = ifq_pkg::NUM_W;
   localparam int SW = ifq_pkg::SCALE_W;
   localparam int XW = DW + 2;

   logic [3:0] valid_ff;

   // stage one: pick sizes and scales
   logic          p1_off_en_ff, p1_off_en_in;
   logic [DW-1:0] p1_dw_ff, p1_dw_in, p1_dh_ff, p1_dh_in;
   logic [SW-1:0] p1_wq_ff, p1_wq_in, p1_hq_ff, p1_hq_in;
   logic [SW-1:0] p1_sx_ff, p1_sx_in, p1_sy_ff, p1_sy_in;

   always_comb begin
      logic          by_width;
      logic [DW-1:0] d1;
      d1       = in_quo[ifq_pkg::LANE_DW];
      p1_wq_in = {in_side.w, ifq_pkg::FRAC_BITS'(0)};
      p1_hq_in = {in_side.h, ifq_pkg::FRAC_BITS'(0)};
      by_width = 1'b0;
      p1_off_en_in = (in_side.mode == ifq_pkg::MODE_FILL) ||
                     (in_side.mode == ifq_pkg::MODE_FIT) ||
                     (in_side.mode == ifq_pkg::MODE_CENTER);
      case (in_side.mode) inside
         ifq_pkg::MODE_CENTER, ifq_pkg::MODE_TILE: begin
            p1_dw_in = {16'b0, in_side.iw, ifq_pkg::FRAC_BITS'(0)};
            p1_dh_in = {16'b0, in_side.ih, ifq_pkg::FRAC_BITS'(0)};
            p1_sx_in = ifq_pkg::ONE_Q;
            p1_sy_in = ifq_pkg::ONE_Q;
         end
         ifq_pkg::MODE_STRETCH: begin
            p1_dw_in = {16'b0, p1_wq_in};
            p1_dh_in = {16'b0, p1_hq_in};
            p1_sx_in = in_quo[ifq_pkg::LANE_SW][SW-1:0];
            p1_sy_in = in_quo[ifq_pkg::LANE_SH][SW-1:0];
         end
         default: begin
            // aspect-keeping modes: compare width scaled to output height
            if (in_side.mode == ifq_pkg::MODE_FIT) begin
               by_width = {16'b0, p1_wq_in} < d1;
            end else begin
               by_width = d1 < {16'b0, p1_wq_in};
            end
            if (by_width) begin
               p1_dw_in = {16'b0, p1_wq_in};
               p1_dh_in = in_quo[ifq_pkg::LANE_DH];
               p1_sx_in = in_quo[ifq_pkg::LANE_SW][SW-1:0];
            end else begin
               p1_dw_in = d1;
               p1_dh_in = {16'b0, p1_hq_in};
               p1_sx_in = in_quo[ifq_pkg::LANE_SH][SW-1:0];
            end
            p1_sy_in = p1_sx_in;
         end
      endcase
   end

   // stage two: size differences
   logic                 p2_off_en_ff;
   logic [DW-1:0]        p2_dw_ff, p2_dh_ff;
   logic [SW-1:0]        p2_wq_ff, p2_hq_ff, p2_sx_ff, p2_sy_ff;
   logic signed [XW-1:0] p2_dx_ff, p2_dx_in, p2_dy_ff, p2_dy_in;

   always_comb begin
      p2_dx_in = $signed({2'b0, p1_dw_ff}) - $signed({18'b0, p1_wq_ff});
      p2_dy_in = $signed({2'b0, p1_dh_ff}) - $signed({18'b0, p1_hq_ff});
   end

   // stage three: halve toward zero, floor on a unit scale
   logic [DW-1:0]        p3_dw_ff, p3_dh_ff;
   logic [SW-1:0]        p3_wq_ff, p3_hq_ff, p3_sx_ff, p3_sy_ff;
   logic signed [XW-1:0] p3_ox_ff, p3_ox_in, p3_oy_ff, p3_oy_in;

   always_comb begin
      logic signed [XW-1:0] tx, ty;
      tx = (p2_dx_ff + $signed({{(XW-1){1'b0}}, p2_dx_ff[XW-1]})) >>> 1;
      ty = (p2_dy_ff + $signed({{(XW-1){1'b0}}, p2_dy_ff[XW-1]})) >>> 1;
      if (p2_sx_ff == ifq_pkg::ONE_Q) begin
         tx = {tx[XW-1:ifq_pkg::FRAC_BITS], ifq_pkg::FRAC_BITS'(0)};
      end
      if (p2_sy_ff == ifq_pkg::ONE_Q) begin
         ty = {ty[XW-1:ifq_pkg::FRAC_BITS], ifq_pkg::FRAC_BITS'(0)};
      end
      p3_ox_in = p2_off_en_ff ? tx : '0;
      p3_oy_in = p2_off_en_ff ? ty : '0;
   end

   // stage four: coverage test and result register
   ifq_pkg::result_type res_ff, res_in;

   always_comb begin
      logic signed [XW:0] ex, ey;
      ex = $signed({p3_ox_ff[XW-1], p3_ox_ff}) + $signed({3'b0, p3_dw_ff});
      ey = $signed({p3_oy_ff[XW-1], p3_oy_ff}) + $signed({3'b0, p3_dh_ff});
      res_in.covers = (p3_ox_ff <= 0) && (p3_oy_ff <= 0) &&
                      ($signed({19'b0, p3_wq_ff}) <= ex) &&
                      ($signed({19'b0, p3_hq_ff}) <= ey);
      res_in.ox = p3_ox_ff[ifq_pkg::OFS_W-1:0];
      res_in.oy = p3_oy_ff[ifq_pkg::OFS_W-1:0];
      res_in.sx = p3_sx_ff;
      res_in.sy = p3_sy_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         p1_off_en_ff <= p1_off_en_in;
         p1_dw_ff     <= p1_dw_in;
         p1_dh_ff     <= p1_dh_in;
         p1_wq_ff     <= p1_wq_in;
         p1_hq_ff     <= p1_hq_in;
         p1_sx_ff     <= p1_sx_in;
         p1_sy_ff     <= p1_sy_in;
         p2_off_en_ff <= p1_off_en_ff;
         p2_dw_ff     <= p1_dw_ff;
         p2_dh_ff     <= p1_dh_ff;
         p2_wq_ff     <= p1_wq_ff;
         p2_hq_ff     <= p1_hq_ff;
         p2_sx_ff     <= p1_sx_ff;
         p2_sy_ff     <= p1_sy_ff;
         p2_dx_ff     <= p2_dx_in;
         p2_dy_ff     <= p2_dy_in;
         p3_dw_ff     <= p2_dw_ff;
         p3_dh_ff     <= p2_dh_ff;
         p3_wq_ff     <= p2_wq_ff;
         p3_hq_ff     <= p2_hq_ff;
         p3_sx_ff     <= p2_sx_ff;
         p3_sy_ff     <= p2_sy_ff;
         p3_ox_ff     <= p3_ox_in;
         p3_oy_ff     <= p3_oy_in;
         res_ff       <= res_in;
      end
   end

   assign out_valid  = valid_ff[3];
   assign out_result = res_ff;

endmodule
`default_nettype wire

>>> rtl/image_fit_transform_q16.sv
// top level: placement scale and offset for a wallpaper image layer
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata: out_width, out_height
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: offset_x, offset_y,
//          |     |                       |   scale_x, scale_y, covers_output
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// one beat per cycle while the result register is empty or taken; the path runs
// through input and multiply stages, 48 divider stages (one quotient bit each) and four output stages.
// the whole pipeline advances when the result register is empty or taken.
// reset clears all valid bits and loads the register defaults; csr is
// always ready.
`timescale 1ns / 1ps
`default_nettype none
module image_fit_transform_q16 (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // out_width[15:0], out_height[31:16]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [167:0]      rsp_tdata,   // offset_x[47:0], offset_y[95:48],
                                          // scale_x[127:96], scale_y[159:128],
                                          // covers_output[160], zero pad
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   logic en;
   logic [2:0]                  mode_ff;
   logic [ifq_pkg::SIZE_W-1:0]  img_w_ff, img_h_ff;

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ifq_pkg::MODE_STRETCH;
         img_w_ff <= ifq_pkg::SIZE_W'(1);
         img_h_ff <= ifq_pkg::SIZE_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            ifq_pkg::CSR_MODE:   mode_ff  <= csr_data[2:0];
            ifq_pkg::CSR_WIDTH:  img_w_ff <= csr_data;
            ifq_pkg::CSR_HEIGHT: img_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic post_valid;
   ifq_pkg::result_type post_result;

   assign en         = !post_valid || rsp_tready;
   assign req_tready = en;

   // stage zero: capture sizes
   logic              s0_valid_ff;
   ifq_pkg::side_type s0_side_ff, s0_side_in;

   always_comb begin
      s0_side_in.mode = mode_ff;
      s0_side_in.w    = ifq_pkg::size_or_one(req_tdata[15:0]);
      s0_side_in.h    = ifq_pkg::size_or_one(req_tdata[31:16]);
      s0_side_in.iw   = ifq_pkg::size_or_one(img_w_ff);
      s0_side_in.ih   = ifq_pkg::size_or_one(img_h_ff);
   end

   // stage one: cross products
   logic                       s1_valid_ff;
   ifq_pkg::side_type          s1_side_ff;
   logic [ifq_pkg::NUM_W-1:0]  s1_num_ff [ifq_pkg::LANES];
   logic [ifq_pkg::SIZE_W-1:0] s1_den_ff [ifq_pkg::LANES];
   logic [31:0]                prod_wh_in, prod_hw_in;

   assign prod_wh_in = s0_side_ff.iw * s0_side_ff.h;
   assign prod_hw_in = s0_side_ff.ih * s0_side_ff.w;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_side_ff <= s0_side_in;
         s1_side_ff <= s0_side_ff;
         s1_num_ff[ifq_pkg::LANE_DW] <= {prod_wh_in, 16'b0};
         s1_num_ff[ifq_pkg::LANE_DH] <= {prod_hw_in, 16'b0};
         s1_num_ff[ifq_pkg::LANE_SW] <= {16'b0, s0_side_ff.iw, 16'b0};
         s1_num_ff[ifq_pkg::LANE_SH] <= {16'b0, s0_side_ff.ih, 16'b0};
         s1_den_ff[ifq_pkg::LANE_DW] <= s0_side_ff.ih;
         s1_den_ff[ifq_pkg::LANE_DH] <= s0_side_ff.iw;
         s1_den_ff[ifq_pkg::LANE_SW] <= s0_side_ff.w;
         s1_den_ff[ifq_pkg::LANE_SH] <= s0_side_ff.h;
      end
   end

   // dividers
   logic                      div_valid;
   ifq_pkg::side_type         div_side;
   logic [ifq_pkg::NUM_W-1:0] div_quo [ifq_pkg::LANES];

   ifq_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_side   (s1_side_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_den_ff),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo   (div_quo)
   );

   // selection, offsets, coverage
   ifq_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (div_valid),
      .in_side    (div_side),
      .in_quo     (div_quo),
      .out_valid  (post_valid),
      .out_result (post_result)
   );

   assign rsp_tvalid = post_valid;
   assign rsp_tdata  = {7'b0, post_result};

   // a covering result never has a positive offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[160] |->
         (rsp_tdata[47] || rsp_tdata[47:0] == '0) &&
         (rsp_tdata[95] || rsp_tdata[95:48] == '0))
      else $error("covered result with positive offset");

   // unit scale gives a whole-pixel offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[127:96] == ifq_pkg::ONE_Q |-> rsp_tdata[15:0] == '0)
      else $error("unit scale offset not floored");

   // no result straight after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
`default_nettype wire

>>> bench/tb_image_fit_transform_q16.sv
// testbench for the image fit transform: predicted scale, offset and coverage per output size
`timescale 1ns / 1ps
`default_nettype none
module tb_image_fit_transform_q16;

   localparam int LATENCY   = 54;
   localparam int WDOG_MAX  = 20000;
   localparam longint ONE64 = 64'sd65536;

   typedef struct packed {
      logic [47:0] ox;
      logic [47:0] oy;
      logic [31:0] sx;
      logic [31:0] sy;
      logic        covers;
   } placement_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   image_fit_transform_q16 uut (.*);

   always #5 clock = ~clock;

   // shadow registers
   logic [2:0]  cfg_mode = 3'd0;
   logic [15:0] cfg_iw = 16'd1;
   logic [15:0] cfg_ih = 16'd1;

   logic [31:0]   size_queue[$];
   placement_type expected_placements[$];
   int  errors = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;

   function automatic longint to_pixels(input logic [15:0] v);
      return (v == 16'd0) ? 64'sd1 : longint'({48'd0, v});
   endfunction

   function automatic longint floor_whole(input longint v);
      return v & ~(ONE64 - 1);
   endfunction

   function automatic placement_type place_layer(input logic [15:0] ow, input logic [15:0] oh);
      longint w, h, iw, ih, wq, hq, dw, dh, sx, sy, ox, oy;
      bit by_width;
      placement_type r;
      w = to_pixels(ow); h = to_pixels(oh);
      iw = to_pixels(cfg_iw); ih = to_pixels(cfg_ih);
      wq = w * ONE64; hq = h * ONE64;
      if (cfg_mode == ifq_pkg::MODE_CENTER || cfg_mode == ifq_pkg::MODE_TILE) begin
         dw = iw * ONE64; dh = ih * ONE64; sx = ONE64; sy = ONE64;
      end else if (cfg_mode == ifq_pkg::MODE_STRETCH) begin
         dw = wq; dh = hq; sx = iw * ONE64 / w; sy = ih * ONE64 / h;
      end else begin
         dw = iw * hq / ih;
         by_width = (cfg_mode == ifq_pkg::MODE_FIT) ? (wq < dw) : (dw < wq);
         if (by_width) begin
            dw = wq; dh = ih * wq / iw; sx = iw * ONE64 / w;
         end else begin
            dh = hq; sx = ih * ONE64 / h;
         end
         sy = sx;
      end
      if (cfg_mode == ifq_pkg::MODE_FILL || cfg_mode == ifq_pkg::MODE_FIT ||
          cfg_mode == ifq_pkg::MODE_CENTER) begin
         ox = (dw - wq) / 2; oy = (dh - hq) / 2;
         if (sx == ONE64) ox = floor_whole(ox);
         if (sy == ONE64) oy = floor_whole(oy);
      end else begin
         ox = 0; oy = 0;
      end
      r.ox = ox[47:0]; r.oy = oy[47:0]; r.sx = sx[31:0]; r.sy = sy[31:0];
      r.covers = (ox <= 0 && oy <= 0 && wq <= ox + dw && hq <= oy + dh);
      return r;
   endfunction

   // driver: one beat per queued size, random gaps
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         expected_placements.push_back(place_layer(req_tdata[15:0], req_tdata[31:16]));
         void'(size_queue.pop_front());
         send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (size_queue.size() > 0 && send_gap == 0) begin
            req_tdata <= size_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (size_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= size_queue[0];
         end
      end
   end

   // monitor: compare each result beat with the oldest prediction
   int recv_gap = 0;
   placement_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[47:0], rsp_tdata[95:48], rsp_tdata[127:96],
                   rsp_tdata[159:128], rsp_tdata[160]};
            if (expected_placements.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               want = expected_placements.pop_front();
               if (got.ox !== want.ox) begin
                  $error("offset_x expected %h got %h", want.ox, got.ox); errors++;
               end
               if (got.oy !== want.oy) begin
                  $error("offset_y expected %h got %h", want.oy, got.oy); errors++;
               end
               if (got.sx !== want.sx) begin
                  $error("scale_x expected %h got %h", want.sx, got.sx); errors++;
               end
               if (got.sy !== want.sy) begin
                  $error("scale_y expected %h got %h", want.sy, got.sy); errors++;
               end
               if (got.covers !== want.covers) begin
                  $error("covers_output expected %b got %b", want.covers, got.covers);
                  errors++;
               end
            end
            recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WDOG_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ifq_pkg::CSR_MODE:   cfg_mode = value[2:0];
         ifq_pkg::CSR_WIDTH:  cfg_iw = value;
         ifq_pkg::CSR_HEIGHT: cfg_ih = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (size_queue.size() == 0 && expected_placements.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom_range(1, 4));
         3, 4: return 16'($urandom);
         default: return 16'($urandom_range(1, 4096));
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0] image_sizes[6];
      int k, m;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes in every mode
      image_sizes = '{16'd1, 16'hffff, 16'd0, 16'd640, 16'd3, 16'd1920};
      for (m = 0; m < 8; m++) begin
         write_reg(ifq_pkg::CSR_MODE, 16'(m));
         write_reg(ifq_pkg::CSR_WIDTH, image_sizes[m % 6]);
         write_reg(ifq_pkg::CSR_HEIGHT, image_sizes[(m + 3) % 6]);
         size_queue.push_back({16'd1, 16'd1});
         size_queue.push_back({16'hffff, 16'hffff});
         size_queue.push_back({16'd0, 16'hffff});
         drain();
      end

      // random phases, one with a long receiver hold-off
      for (k = 0; k < 28; k++) begin
         write_reg(ifq_pkg::CSR_MODE, 16'($urandom_range(0, 7)));
         write_reg(ifq_pkg::CSR_WIDTH, pick_size());
         write_reg(ifq_pkg::CSR_HEIGHT, pick_size());
         if (k == 3) hold_cycles = 300;
         for (m = 0; m < 50; m++)
            size_queue.push_back({pick_size(), pick_size()});
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_placements.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
